// File: rtl/hist_pkg.sv
// Shared types and constants for the histogram accumulator.
package hist_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int BIN_ADDR_W    = 16;
    localparam int COUNT_OUT_W   = 32;
    localparam int OPCODE_W      = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 5;
    localparam int AXIS_BITS_W   = 5;
    localparam logic [AXIS_BITS_W-1:0] AXIS_BITS_RST = 5'd8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ACCUMULATE = 2'd0,
        OP_READ       = 2'd1,
        OP_READ_CLEAR = 2'd2,
        OP_IGNORE     = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_BITS  = 2'd0,
        CFG_TWO_DIM    = 2'd1,
        CFG_SIGNED     = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    // request from the front end into the counter store
    typedef struct packed {
        logic vld;
        t_op  op;
    } t_req;

endpackage

// File: rtl/hist_bin_map.sv
// Sample to bin index mapping for 1D and joint 2D modes.
module hist_bin_map #(
    parameter int SAMPLE_BITS   = 16,
    parameter int BIN_ADDR_BITS = 16
) (
    input  logic [hist_pkg::SAMPLE_W-1:0]    i_sample_x,
    input  logic [hist_pkg::SAMPLE_W-1:0]    i_sample_y,
    input  logic [hist_pkg::AXIS_BITS_W-1:0] i_axis_bits,
    input  logic                             i_two_dim,
    input  logic                             i_signed,
    output logic [BIN_ADDR_BITS-1:0]         o_bin
);
    import hist_pkg::*;

    localparam int LIM_1D = (SAMPLE_BITS < BIN_ADDR_BITS) ? SAMPLE_BITS : BIN_ADDR_BITS;
    localparam int LIM_2D = (SAMPLE_BITS < BIN_ADDR_BITS / 2) ? SAMPLE_BITS
                                                              : BIN_ADDR_BITS / 2;
    localparam int WW     = SAMPLE_BITS + BIN_ADDR_BITS;

    logic [AXIS_BITS_W-1:0] bits_lo;
    logic [AXIS_BITS_W-1:0] lim;
    logic [AXIS_BITS_W-1:0] eff_bits;
    logic [AXIS_BITS_W-1:0] shamt;
    logic [SAMPLE_BITS-1:0] vx;
    logic [SAMPLE_BITS-1:0] vy;
    logic [SAMPLE_BITS-1:0] xi;
    logic [SAMPLE_BITS-1:0] yi;
    logic [SAMPLE_BITS-1:0] flip;
    logic [WW-1:0]          xw;
    logic [WW-1:0]          joint;

    always_comb begin
        bits_lo  = (i_axis_bits == '0) ? AXIS_BITS_W'(1) : i_axis_bits;
        lim      = i_two_dim ? AXIS_BITS_W'(LIM_2D) : AXIS_BITS_W'(LIM_1D);
        eff_bits = (bits_lo > lim) ? lim : bits_lo;
        shamt    = AXIS_BITS_W'(SAMPLE_BITS) - eff_bits;
        vx       = SAMPLE_BITS'(i_sample_x);
        vy       = SAMPLE_BITS'(i_sample_y);
        // signed layout: top bit of each axis index inverted
        flip     = i_signed ? (SAMPLE_BITS'(1) << (eff_bits - AXIS_BITS_W'(1))) : '0;
        xi       = (vx >> shamt) ^ flip;
        yi       = (vy >> shamt) ^ flip;
        xw       = WW'(xi);
        joint    = (xw << eff_bits) | WW'(yi);
        o_bin    = i_two_dim ? joint[BIN_ADDR_BITS-1:0] : xw[BIN_ADDR_BITS-1:0];
    end

endmodule

// File: rtl/hist_store.sv
// Counter memory with clearing sweep, read-modify-write stage and forwarding.
module hist_store #(
    parameter int BIN_ADDR_BITS = 16,
    parameter int COUNT_BITS    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  hist_pkg::t_req           i_req,
    input  logic [BIN_ADDR_BITS-1:0] i_addr,
    output logic                     o_clearing,
    output logic                     o_res_vld,
    output logic [COUNT_BITS-1:0]    o_res_count,
    output logic                     o_res_sat
);
    import hist_pkg::*;

    localparam int DEPTH = 1 << BIN_ADDR_BITS;

    logic [COUNT_BITS-1:0]    r_mem [DEPTH];
    logic [COUNT_BITS-1:0]    r_rd_data;

    logic                     r_clr;
    logic                     n_clr;
    logic [BIN_ADDR_BITS-1:0] r_clr_addr;
    logic [BIN_ADDR_BITS-1:0] n_clr_addr;

    logic                     r_s1_vld;
    t_op                      r_s1_op;
    logic [BIN_ADDR_BITS-1:0] r_s1_addr;
    logic                     r_fwd_hit;
    logic [COUNT_BITS-1:0]    r_fwd_data;

    logic                     r_res_vld;
    logic [COUNT_BITS-1:0]    r_res_count;
    logic                     r_res_sat;

    logic                     rd_en;
    logic [COUNT_BITS-1:0]    cur;
    logic                     s1_wr;
    logic [COUNT_BITS-1:0]    s1_data;
    logic                     wr_en;
    logic [BIN_ADDR_BITS-1:0] wr_addr;
    logic [COUNT_BITS-1:0]    wr_data;

    assign rd_en = i_req.vld && (i_req.op != OP_IGNORE);

    // same-bin write in the cycle of the read is not seen by the memory
    assign cur = r_fwd_hit ? r_fwd_data : r_rd_data;

    always_comb begin
        s1_wr   = 1'b0;
        s1_data = cur;
        unique case (r_s1_op)
            OP_ACCUMULATE: begin
                s1_wr   = r_s1_vld;
                s1_data = (&cur) ? cur : cur + COUNT_BITS'(1);
            end
            OP_READ_CLEAR: begin
                s1_wr   = r_s1_vld;
                s1_data = '0;
            end
            OP_READ, OP_IGNORE: begin
                s1_wr   = 1'b0;
                s1_data = cur;
            end
            default: begin
                s1_wr   = 1'b0;
                s1_data = cur;
            end
        endcase
    end

    always_comb begin
        wr_en   = r_clr | s1_wr;
        wr_addr = r_clr ? r_clr_addr : r_s1_addr;
        wr_data = r_clr ? '0 : s1_data;
    end

    always_comb begin
        n_clr_addr = r_clr_addr + BIN_ADDR_BITS'(1);
        n_clr      = r_clr && (r_clr_addr != '1);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_s1_vld   <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            r_clr      <= n_clr;
            r_clr_addr <= r_clr ? n_clr_addr : r_clr_addr;
            r_s1_vld   <= rd_en;
            r_res_vld  <= r_s1_vld && (r_s1_op != OP_ACCUMULATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_op    <= i_req.op;
            r_s1_addr  <= i_addr;
            r_fwd_hit  <= wr_en && (wr_addr == i_addr);
            r_fwd_data <= wr_data;
        end
        r_res_count <= cur;
        r_res_sat   <= &cur;
    end

    assign o_clearing  = r_clr;
    assign o_res_vld   = r_res_vld;
    assign o_res_count = r_res_count;
    assign o_res_sat   = r_res_sat;

endmodule

// File: rtl/histogram_1d_2d_accumulator.sv
// Top level of the 1D / 2D histogram accumulator.
//
//  channel   direction  handshake                       payload
//  command   in         i_start, o_busy                 i_opcode, i_sample_x, i_sample_y,
//                                                       i_bin_address
//  result    out        o_result_valid (strobe)         o_bin_count, o_count_saturated
//  config    in         i_cfg_valid, o_cfg_ready        i_cfg_index, i_cfg_data
//
//  One command per cycle while o_busy is low; a read result is registered after
//  the read-modify-write stage. Accumulates to the same bin on consecutive cycles
//  are forwarded around the registered memory read, so the memory ports set the
//  rate. After reset the counter memory is swept to zero, one bin per cycle, over
//  all 2^BIN_ADDR_BITS bins (65536 by default), with o_busy high throughout.
//  The result strobe cannot be held off; config writes are always taken.
module histogram_1d_2d_accumulator #(
    parameter int SAMPLE_BITS   = 16,
    parameter int BIN_ADDR_BITS = 16,
    parameter int COUNT_BITS    = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [hist_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [hist_pkg::SAMPLE_W-1:0]     i_sample_x,
    input  logic [hist_pkg::SAMPLE_W-1:0]     i_sample_y,
    input  logic [hist_pkg::BIN_ADDR_W-1:0]   i_bin_address,
    output logic                              o_result_valid,
    output logic [hist_pkg::COUNT_OUT_W-1:0]  o_bin_count,
    output logic                              o_count_saturated,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hist_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hist_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hist_pkg::*;

    logic [AXIS_BITS_W-1:0]   r_axis_bits;
    logic                     r_two_dim;
    logic                     r_signed;

    logic                     clearing;
    logic                     accept;
    t_op                      op;
    t_req                     req;
    logic [BIN_ADDR_BITS-1:0] map_bin;
    logic [BIN_ADDR_BITS-1:0] addr;
    logic [COUNT_BITS-1:0]    res_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_bits <= AXIS_BITS_RST;
            r_two_dim   <= 1'b0;
            r_signed    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_AXIS_BITS: r_axis_bits <= i_cfg_data[AXIS_BITS_W-1:0];
                CFG_TWO_DIM:   r_two_dim   <= i_cfg_data[0];
                CFG_SIGNED:    r_signed    <= i_cfg_data[0];
                CFG_UNUSED:    ;
                default:       ;
            endcase
        end
    end

    hist_bin_map #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .BIN_ADDR_BITS (BIN_ADDR_BITS)
    ) u_map (
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .i_axis_bits (r_axis_bits),
        .i_two_dim   (r_two_dim),
        .i_signed    (r_signed),
        .o_bin       (map_bin)
    );

    assign accept  = i_start && !clearing;
    assign op      = t_op'(i_opcode);
    assign addr    = (op == OP_ACCUMULATE) ? map_bin : BIN_ADDR_BITS'(i_bin_address);
    assign req.vld = accept;
    assign req.op  = op;

    hist_store #(
        .BIN_ADDR_BITS (BIN_ADDR_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_addr      (addr),
        .o_clearing  (clearing),
        .o_res_vld   (o_result_valid),
        .o_res_count (res_count),
        .o_res_sat   (o_count_saturated)
    );

    assign o_busy      = clearing;
    assign o_bin_count = COUNT_OUT_W'(res_count);

endmodule

// File: rtl/hist_checker.sv
// Port-level checks on the histogram accumulator, bound to the top level.
module hist_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_start,
    input logic                              o_busy,
    input logic [hist_pkg::OPCODE_W-1:0]     i_opcode,
    input logic [hist_pkg::BIN_ADDR_W-1:0]   i_bin_address,
    input logic                              o_result_valid,
    input logic [hist_pkg::COUNT_OUT_W-1:0]  o_bin_count
);
    import hist_pkg::*;

    logic acc_rd;
    logic acc_any;

    assign acc_any = i_start && !o_busy;
    assign acc_rd  = acc_any && (i_opcode == OP_READ || i_opcode == OP_READ_CLEAR);

    // every read word comes back as a result strobe
    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_rd |-> ##2 o_result_valid)
        else $error("read word produced no result");

    // no result without an earlier read word
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(acc_rd, 2))
        else $error("result strobe without a read word");

    // the clearing sweep runs once, after reset only
    a_busy_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$rose(o_busy))
        else $error("busy rose outside reset");

    // read straight after read-and-clear of the same bin sees zero
    a_clear_forwarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_any && i_opcode == OP_READ_CLEAR ##1
         acc_rd && i_bin_address == $past(i_bin_address)) |-> ##2 (o_bin_count == '0))
        else $error("cleared bin read back non-zero");

endmodule

bind histogram_1d_2d_accumulator hist_checker u_hist_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .i_opcode       (i_opcode),
    .i_bin_address  (i_bin_address),
    .o_result_valid (o_result_valid),
    .o_bin_count    (o_bin_count)
);

// File: tb/sv/histogram_1d_2d_accumulator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 1D / 2D histogram accumulator, with a bin-count predictor.
module histogram_1d_2d_accumulator_tb;
    import hist_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 155;
    localparam int N_DIRECTED    = 20;
    localparam int N_FIXED_SET   = 10;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic                   saturated;
    } t_bin_reply;

    typedef struct packed {
        t_op                   op;
        logic [SAMPLE_W-1:0]   x;
        logic [SAMPLE_W-1:0]   y;
        logic [BIN_ADDR_W-1:0] addr;
        logic                  typed;
        logic [COUNT_OUT_W-1:0] count;
        logic                  sat;
    } t_stim_row;

    typedef struct packed {
        logic [AXIS_BITS_W-1:0] bits;
        logic                   two;
        logic                   sgn;
    } t_setting;

    // rows with typed replies: empty store after reset, or a bin just cleared
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{OP_READ,       16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd0, 1'b0},
        '{OP_READ,       16'h0000, 16'h0000, 16'hFFFF, 1'b1, 32'd0, 1'b0},
        '{OP_READ_CLEAR, 16'h0000, 16'h0000, 16'h5A5A, 1'b1, 32'd0, 1'b0},
        '{OP_ACCUMULATE, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 32'd0, 1'b0},
        '{OP_ACCUMULATE, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 32'd0, 1'b0},
        '{OP_ACCUMULATE, 16'h00FF, 16'hAAAA, 16'h0000, 1'b0, 32'd0, 1'b0},
        '{OP_ACCUMULATE, 16'h0080, 16'h5555, 16'h0000, 1'b0, 32'd0, 1'b0},
        '{OP_IGNORE,     16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd0, 1'b0},
        '{OP_READ,       16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd0, 1'b0},
        '{OP_READ_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd0, 1'b0},
        '{OP_READ,       16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd0, 1'b0},
        '{OP_READ,       16'h0000, 16'h0000, 16'h00FF, 1'b0, 32'd0, 1'b0},
        '{OP_ACCUMULATE, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'd0, 1'b0},
        '{OP_ACCUMULATE, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'd0, 1'b0},
        '{OP_ACCUMULATE, 16'h8000, 16'hFFFF, 16'h0000, 1'b0, 32'd0, 1'b0},
        '{OP_READ_CLEAR, 16'h0000, 16'h0000, 16'h0080, 1'b0, 32'd0, 1'b0},
        '{OP_READ,       16'h0000, 16'h0000, 16'h007F, 1'b0, 32'd0, 1'b0},
        '{OP_IGNORE,     16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0, 1'b0},
        '{OP_READ_CLEAR, 16'h0000, 16'h0000, 16'h00FF, 1'b0, 32'd0, 1'b0},
        '{OP_READ,       16'h0000, 16'h0000, 16'hFFFF, 1'b1, 32'd0, 1'b0}
    };

    // extremes of axis width in both modes, zero and oversize included
    localparam t_setting FIXED_SET [N_FIXED_SET] = '{
        '{5'd8,  1'b0, 1'b0}, '{5'd0,  1'b0, 1'b0}, '{5'd1,  1'b0, 1'b1},
        '{5'd16, 1'b0, 1'b0}, '{5'd31, 1'b0, 1'b1}, '{5'd16, 1'b1, 1'b0},
        '{5'd8,  1'b1, 1'b1}, '{5'd1,  1'b1, 1'b1}, '{5'd0,  1'b1, 1'b0},
        '{5'd31, 1'b1, 1'b1}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_start = 1'b0;
    logic                     o_busy;
    logic [OPCODE_W-1:0]      i_opcode = OP_IGNORE;
    logic [SAMPLE_W-1:0]      i_sample_x = '0;
    logic [SAMPLE_W-1:0]      i_sample_y = '0;
    logic [BIN_ADDR_W-1:0]    i_bin_address = '0;
    logic                     o_result_valid;
    logic [COUNT_OUT_W-1:0]   o_bin_count;
    logic                     o_count_saturated;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = CFG_UNUSED;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    // typed reply travelling alongside the command word
    logic                     row_typed = 1'b0;
    logic [COUNT_OUT_W-1:0]   row_count = '0;
    logic                     row_sat = 1'b0;

    logic [COUNT_OUT_W-1:0]   bin_tally [1 << BIN_ADDR_W];
    t_bin_reply               reads_due [$];
    logic [AXIS_BITS_W-1:0]   axis_bits_now = AXIS_BITS_RST;
    logic                     two_dim_now = 1'b0;
    logic                     signed_now = 1'b0;
    int                       mismatches = 0;
    int                       cycle_count = 0;
    bit                       burst_mode = 1'b0;

    histogram_1d_2d_accumulator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_opcode          (i_opcode),
        .i_sample_x        (i_sample_x),
        .i_sample_y        (i_sample_y),
        .i_bin_address     (i_bin_address),
        .o_result_valid    (o_result_valid),
        .o_bin_count       (o_bin_count),
        .o_count_saturated (o_count_saturated),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // bin that a sample (or x/y pair) lands in under the given settings
    function automatic logic [BIN_ADDR_W-1:0] bin_of(input logic [SAMPLE_W-1:0] sx,
                                                      input logic [SAMPLE_W-1:0] sy,
                                                      input logic [AXIS_BITS_W-1:0] bits_cfg,
                                                      input logic two, input logic sgn);
        int          lim;
        int          b;
        logic [31:0] xi;
        logic [31:0] yi;
        lim = two ? BIN_ADDR_W / 2 : BIN_ADDR_W;
        if (lim > SAMPLE_W) lim = SAMPLE_W;
        b = (bits_cfg == '0) ? 1 : int'(bits_cfg);
        if (b > lim) b = lim;
        xi = 32'(sx) >> (SAMPLE_W - b);
        yi = 32'(sy) >> (SAMPLE_W - b);
        if (sgn) begin
            xi ^= 32'd1 << (b - 1);
            yi ^= 32'd1 << (b - 1);
        end
        return two ? BIN_ADDR_W'((xi << b) + yi) : BIN_ADDR_W'(xi);
    endfunction

    task automatic flag_mismatch(input string what, input t_bin_reply want);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch (%s) at cycle %0d: expected count %0h sat %0b,",
                      " got count %0h sat %0b"},
                     what, cycle_count, want.count, want.saturated, o_bin_count,
                     o_count_saturated);
    endtask

    // check replies, mirror register writes, and predict each accepted word
    always @(posedge i_clk) begin : bin_predict
        t_bin_reply             want;
        logic [BIN_ADDR_W-1:0]  slot;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (reads_due.size() == 0) begin
                    want = '0;
                    flag_mismatch("reply with no read pending", want);
                end else begin
                    want = reads_due.pop_front();
                    if (o_bin_count !== want.count || o_count_saturated !== want.saturated)
                        flag_mismatch("bin reply", want);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_AXIS_BITS: axis_bits_now = i_cfg_data[AXIS_BITS_W-1:0];
                    CFG_TWO_DIM:   two_dim_now = i_cfg_data[0];
                    CFG_SIGNED:    signed_now = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !o_busy) begin
                case (t_op'(i_opcode))
                    OP_ACCUMULATE: begin
                        slot = bin_of(i_sample_x, i_sample_y, axis_bits_now, two_dim_now,
                                      signed_now);
                        if (bin_tally[slot] != '1) bin_tally[slot] = bin_tally[slot] + 1'b1;
                    end
                    OP_READ, OP_READ_CLEAR: begin
                        want.count = bin_tally[i_bin_address];
                        want.saturated = (want.count == '1);
                        if (row_typed) begin
                            want.count = row_count;
                            want.saturated = row_sat;
                        end
                        reads_due.push_back(want);
                        if (t_op'(i_opcode) == OP_READ_CLEAR) bin_tally[i_bin_address] = '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    task automatic drive_word(input t_op op, input logic [SAMPLE_W-1:0] sx,
                              input logic [SAMPLE_W-1:0] sy, input logic [BIN_ADDR_W-1:0] addr,
                              input logic typed, input logic [COUNT_OUT_W-1:0] cnt,
                              input logic sat);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_opcode      <= op;
        i_sample_x    <= sx;
        i_sample_y    <= sy;
        i_bin_address <= addr;
        row_typed     <= typed;
        row_count     <= cnt;
        row_sat       <= sat;
        do @(posedge i_clk); while (o_busy);
    endtask

    // pause the sender until every read has answered, then let the pipe empty
    task automatic wait_for_replies();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (reads_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // valid stays up across the group; lowered once at the end
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    initial begin : stimulus
        t_setting               cur;
        logic [SAMPLE_W-1:0]    pool_x [6];
        logic [SAMPLE_W-1:0]    pool_y [6];
        logic [BIN_ADDR_W-1:0]  hot_bins [$];
        logic [SAMPLE_W-1:0]    sx;
        logic [SAMPLE_W-1:0]    sy;
        logic [BIN_ADDR_W-1:0]  addr;
        t_op                    op;
        int                     pick;
        int                     words;

        for (int i = 0; i < (1 << BIN_ADDR_W); i++) bin_tally[i] = '0;
        cur = '{AXIS_BITS_RST, 1'b0, 1'b0};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // clearing sweep holds busy high
        do @(posedge i_clk); while (o_busy);

        for (int r = 0; r < N_DIRECTED; r++)
            drive_word(DIRECTED[r].op, DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].addr,
                       DIRECTED[r].typed, DIRECTED[r].count, DIRECTED[r].sat);

        for (int p = 0; p < PHASES; p++) begin
            wait_for_replies();
            if (p < N_FIXED_SET) begin
                cur = FIXED_SET[p];
            end else begin
                cur.bits = AXIS_BITS_W'($urandom_range(1, 16));
                cur.two  = 1'($urandom);
                cur.sgn  = 1'($urandom);
            end
            write_reg(CFG_AXIS_BITS, cur.bits);
            write_reg(CFG_TWO_DIM, {(CFG_DATA_W-1)'($urandom), cur.two});
            write_reg(CFG_SIGNED, {(CFG_DATA_W-1)'($urandom), cur.sgn});
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            i_cfg_valid <= 1'b0;

            // a small pool of samples per phase so that bins build up real counts
            for (int k = 0; k < 6; k++) begin
                pool_x[k] = SAMPLE_W'($urandom);
                pool_y[k] = SAMPLE_W'($urandom);
            end
            hot_bins.delete();
            words = 0;
            while (words < PHASE_WORDS) begin
                if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
                pick = $urandom_range(0, 99);
                sx   = SAMPLE_W'($urandom);
                sy   = SAMPLE_W'($urandom);
                addr = BIN_ADDR_W'($urandom);
                if (pick < 55) begin
                    op = OP_ACCUMULATE;
                    if ($urandom_range(0, 4) != 0) begin
                        sx = pool_x[$urandom_range(0, 5)];
                        sy = pool_y[$urandom_range(0, 5)];
                    end
                    hot_bins.push_back(bin_of(sx, sy, cur.bits, cur.two, cur.sgn));
                    if (hot_bins.size() > 16) void'(hot_bins.pop_front());
                end else if (pick < 95) begin
                    op = (pick < 75) ? OP_READ : OP_READ_CLEAR;
                    if (hot_bins.size() != 0 && $urandom_range(0, 9) < 7)
                        addr = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
                end else begin
                    op = OP_IGNORE;
                end
                drive_word(op, sx, sy, addr, 1'b0, '0, 1'b0);
                if (op != OP_IGNORE) words++;
                if ($urandom_range(0, 99) == 0) wait_for_replies();
            end
        end

        wait_for_replies();
        if (mismatches == 0 && reads_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
